// ===== sv/cgp_pkg.sv =====
package cgp_pkg;

    // field widths
    localparam int CoordW = 20;
    localparam int RegW   = 16;
    localparam int CfgIdxW = 3;

    // internal datapath widths
    localparam int TrigW  = 18;   // rounded pair product, q14
    localparam int NumW   = 58;   // numerator after focal scaling
    localparam int DenW   = 41;   // twice the depth magnitude
    localparam int QuoW   = 21;   // quotient bits kept before saturation

    localparam logic signed [CoordW-1:0] PixMax = 20'sd524287;
    localparam logic signed [CoordW-1:0] PixMin = -20'sd524288;

    // register indexes on the config port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_COS_YAW   = 3'd0,
        CFG_SIN_YAW   = 3'd1,
        CFG_COS_PITCH = 3'd2,
        CFG_SIN_PITCH = 3'd3,
        CFG_MOUNT_H   = 3'd4,
        CFG_CENTER_X  = 3'd5,
        CFG_CENTER_Y  = 3'd6,
        CFG_FOCAL     = 3'd7
    } cfg_idx_t;

    // q28 product rounded to q14, ties away from zero
    function automatic logic signed [TrigW-1:0] round_q14(input logic signed [31:0] v);
        logic [32:0] mag;
        logic [32:0] r;
        begin
            mag = v[31] ? 33'(-$signed({v[31], v})) : {1'b0, v};
            r = (mag + 33'd8192) >> 14;
            round_q14 = v[31] ? -$signed(r[TrigW-1:0]) : $signed(r[TrigW-1:0]);
        end
    endfunction

endpackage

// ===== sv/camera_ground_projection.sv =====
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------
// in        | in_valid / in_stall   | world_lateral, world_forward
// out       | out_valid / out_stall | image_col, image_row, zero_depth
// cfg       | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one beat per clock in and out unless a held output beat stalls; out_valid follows
// 7 front stages, 21 divider stages of one quotient bit each and 1 output register
// rst_n clears all valid bits and loads the register reset values
// a stalled output beat freezes every stage, in_stall follows at once
module camera_ground_projection (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [cgp_pkg::CoordW-1:0]      world_lateral,
    input  logic signed [cgp_pkg::CoordW-1:0]      world_forward,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cgp_pkg::CoordW-1:0]      image_col,
    output logic signed [cgp_pkg::CoordW-1:0]      image_row,
    output logic                                   zero_depth,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [cgp_pkg::CfgIdxW-1:0]            cfg_index,
    input  logic [cgp_pkg::RegW-1:0]               cfg_data
);

    localparam int NStg = 6;
    localparam int QW   = cgp_pkg::QuoW;
    localparam int DW   = cgp_pkg::DenW;

    // config registers
    logic [cgp_pkg::RegW-1:0] cyw_reg, syw_reg, cp_reg, sp_reg;
    logic [cgp_pkg::RegW-1:0] h_reg, cx_reg, cy_reg, f_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cyw_reg <= 16'd16384;
            syw_reg <= 16'd0;
            cp_reg  <= 16'd16384;
            sp_reg  <= 16'd0;
            h_reg   <= 16'd1200;
            cx_reg  <= 16'd10240;
            cy_reg  <= 16'd5760;
            f_reg   <= 16'd16000;
        end
        else if (cfg_valid)
        begin
            unique case (cgp_pkg::cfg_idx_t'(cfg_index))
                cgp_pkg::CFG_COS_YAW:   cyw_reg <= cfg_data;
                cgp_pkg::CFG_SIN_YAW:   syw_reg <= cfg_data;
                cgp_pkg::CFG_COS_PITCH: cp_reg  <= cfg_data;
                cgp_pkg::CFG_SIN_PITCH: sp_reg  <= cfg_data;
                cgp_pkg::CFG_MOUNT_H:   h_reg   <= cfg_data;
                cgp_pkg::CFG_CENTER_X:  cx_reg  <= cfg_data;
                cgp_pkg::CFG_CENTER_Y:  cy_reg  <= cfg_data;
                cgp_pkg::CFG_FOCAL:     f_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [15:0] cyw, syw, cp, sp;
    logic signed [16:0] h_s, f_s;
    assign cyw = $signed(cyw_reg);
    assign syw = $signed(syw_reg);
    assign cp  = $signed(cp_reg);
    assign sp  = $signed(sp_reg);
    assign h_s = $signed({1'b0, h_reg});
    assign f_s = $signed({1'b0, f_reg});

    // global advance: everything moves unless the output beat is held
    logic en;
    logic out_valid_reg;
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    logic [NStg:1] v_reg;

    // stage 1: trig pair products and first rotation products
    logic signed [19:0] x1_reg, z1_reg;
    logic signed [17:0] a1_reg, b1_reg, c1_reg, d1_reg;
    logic signed [35:0] xa1_reg, xb1_reg;
    logic signed [32:0] ch1_reg, sh1_reg;
    logic signed [31:0] pa, pb, pc, pd;
    assign pa = sp * syw;
    assign pb = cyw * sp;
    assign pc = cp * syw;
    assign pd = cp * cyw;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= world_lateral;
            z1_reg  <= world_forward;
            a1_reg  <= cgp_pkg::round_q14(pa);
            b1_reg  <= cgp_pkg::round_q14(pb);
            c1_reg  <= cgp_pkg::round_q14(pc);
            d1_reg  <= cgp_pkg::round_q14(pd);
            xa1_reg <= 36'(cyw * world_lateral);
            xb1_reg <= 36'(syw * world_forward);
            ch1_reg <= 33'(cp * h_s);
            sh1_reg <= 33'(sp * h_s);
        end
    end

    // stage 2: second rotation products, lateral numerator
    logic signed [39:0] xn2_reg;
    logic signed [37:0] ax2_reg, bz2_reg, cx2_reg, dz2_reg;
    logic signed [32:0] ch2_reg, sh2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn2_reg <= 40'(xa1_reg) + 40'(xb1_reg);
            ax2_reg <= 38'(a1_reg * x1_reg);
            bz2_reg <= 38'(b1_reg * z1_reg);
            cx2_reg <= 38'(c1_reg * x1_reg);
            dz2_reg <= 38'(d1_reg * z1_reg);
            ch2_reg <= ch1_reg;
            sh2_reg <= sh1_reg;
        end
    end

    // stage 3: vertical numerator and depth
    logic signed [39:0] xn3_reg, yn3_reg, zn3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xn3_reg <= xn2_reg;
            yn3_reg <= 40'(ax2_reg) + 40'(ch2_reg) - 40'(bz2_reg);
            zn3_reg <= 40'(sh2_reg) + 40'(dz2_reg) - 40'(cx2_reg);
        end
    end

    // stage 4: focal scaling split into two partial products
    logic [35:0]        xlo4_reg, ylo4_reg;
    logic signed [36:0] xhi4_reg, yhi4_reg;
    logic signed [39:0] zn4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xlo4_reg <= 36'(xn3_reg[19:0] * f_reg);
            ylo4_reg <= 36'(yn3_reg[19:0] * f_reg);
            xhi4_reg <= 37'($signed(xn3_reg[39:20]) * f_s);
            yhi4_reg <= 37'($signed(yn3_reg[39:20]) * f_s);
            zn4_reg  <= zn3_reg;
        end
    end

    // stage 5: combine partial products
    logic signed [cgp_pkg::NumW-1:0] nx5_reg, ny5_reg;
    logic signed [39:0]              zn5_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx5_reg <= (58'(xhi4_reg) <<< 20) + $signed({22'd0, xlo4_reg});
            ny5_reg <= (58'(yhi4_reg) <<< 20) + $signed({22'd0, ylo4_reg});
            zn5_reg <= zn4_reg;
        end
    end

    // stage 6: magnitudes and quotient signs
    logic [cgp_pkg::NumW-1:0] mx6_reg, my6_reg;
    logic [DW-1:0]            d6_reg;
    logic                     negx6_reg, negy6_reg, zero6_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mx6_reg   <= nx5_reg[57] ? 58'(-nx5_reg) : 58'(nx5_reg);
            my6_reg   <= ny5_reg[57] ? 58'(-ny5_reg) : 58'(ny5_reg);
            d6_reg    <= zn5_reg[39] ? {40'(-zn5_reg), 1'b0} : {40'(zn5_reg), 1'b0};
            negx6_reg <= nx5_reg[57] ^ zn5_reg[39];
            negy6_reg <= ny5_reg[57] ^ zn5_reg[39];
            zero6_reg <= (zn5_reg == 40'sd0);
        end
    end

    // stage 7: rounding bias of one depth magnitude, overflow check, divider seed
    logic [cgp_pkg::NumW-1:0] n2x, n2y;
    assign n2x = {mx6_reg[56:0], 1'b0} + 58'(d6_reg[DW-1:1]);
    assign n2y = {my6_reg[56:0], 1'b0} + 58'(d6_reg[DW-1:1]);

    logic [DW-1:0] remx_reg [0:QW];
    logic [DW-1:0] remy_reg [0:QW];
    logic [QW-1:0] lox_reg  [0:QW];
    logic [QW-1:0] loy_reg  [0:QW];
    logic [QW-1:0] qx_reg   [0:QW];
    logic [QW-1:0] qy_reg   [0:QW];
    logic [DW-1:0] d_reg    [0:QW];
    logic          negx_reg [0:QW];
    logic          negy_reg [0:QW];
    logic          ovfx_reg [0:QW];
    logic          ovfy_reg [0:QW];
    logic          zero_reg [0:QW];
    logic          dv_reg   [0:QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remx_reg[0] <= DW'(n2x[57:21]);
            remy_reg[0] <= DW'(n2y[57:21]);
            lox_reg[0]  <= n2x[20:0];
            loy_reg[0]  <= n2y[20:0];
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            d_reg[0]    <= d6_reg;
            negx_reg[0] <= negx6_reg;
            negy_reg[0] <= negy6_reg;
            ovfx_reg[0] <= (DW'(n2x[57:21]) >= d6_reg);
            ovfy_reg[0] <= (DW'(n2y[57:21]) >= d6_reg);
            zero_reg[0] <= zero6_reg;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            dv_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg     <= {v_reg[NStg-1:1], in_valid};
            dv_reg[0] <= v_reg[NStg];
        end
    end

    // divider stages: one quotient bit of each axis per stage
    for (genvar k = 1; k <= QW; k++)
    begin : g_div
        logic [DW:0] tx, ty;
        logic        gex, gey;
        assign tx  = {remx_reg[k-1], lox_reg[k-1][QW-k]};
        assign ty  = {remy_reg[k-1], loy_reg[k-1][QW-k]};
        assign gex = (tx >= {1'b0, d_reg[k-1]});
        assign gey = (ty >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                remx_reg[k] <= gex ? DW'(tx - {1'b0, d_reg[k-1]}) : tx[DW-1:0];
                remy_reg[k] <= gey ? DW'(ty - {1'b0, d_reg[k-1]}) : ty[DW-1:0];
                lox_reg[k]  <= lox_reg[k-1];
                loy_reg[k]  <= loy_reg[k-1];
                qx_reg[k]   <= {qx_reg[k-1][QW-2:0], gex};
                qy_reg[k]   <= {qy_reg[k-1][QW-2:0], gey};
                d_reg[k]    <= d_reg[k-1];
                negx_reg[k] <= negx_reg[k-1];
                negy_reg[k] <= negy_reg[k-1];
                ovfx_reg[k] <= ovfx_reg[k-1];
                ovfy_reg[k] <= ovfy_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k] <= 1'b0;
            else if (en)
                dv_reg[k] <= dv_reg[k-1];
        end
    end

    // final: sign, principal point offset, saturation; zero depth gives the principal point
    logic signed [22:0] sx, sy, tot_x, tot_y;
    logic signed [19:0] col_next, row_next;

    always_comb
    begin
        sx    = negx_reg[QW] ? -$signed({2'b00, qx_reg[QW]}) : $signed({2'b00, qx_reg[QW]});
        sy    = negy_reg[QW] ? -$signed({2'b00, qy_reg[QW]}) : $signed({2'b00, qy_reg[QW]});
        tot_x = sx + $signed({7'd0, cx_reg});
        tot_y = sy + $signed({7'd0, cy_reg});

        if (zero_reg[QW])
            col_next = $signed({4'd0, cx_reg});
        else if (ovfx_reg[QW])
            col_next = negx_reg[QW] ? cgp_pkg::PixMin : cgp_pkg::PixMax;
        else if (tot_x > 23'(cgp_pkg::PixMax))
            col_next = cgp_pkg::PixMax;
        else if (tot_x < 23'(cgp_pkg::PixMin))
            col_next = cgp_pkg::PixMin;
        else
            col_next = tot_x[19:0];

        if (zero_reg[QW])
            row_next = $signed({4'd0, cy_reg});
        else if (ovfy_reg[QW])
            row_next = negy_reg[QW] ? cgp_pkg::PixMin : cgp_pkg::PixMax;
        else if (tot_y > 23'(cgp_pkg::PixMax))
            row_next = cgp_pkg::PixMax;
        else if (tot_y < 23'(cgp_pkg::PixMin))
            row_next = cgp_pkg::PixMin;
        else
            row_next = tot_y[19:0];
    end

    // output beat register
    logic signed [19:0] col_reg, row_reg;
    logic               zd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            zd_reg  <= zero_reg[QW];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[QW];
    end

    assign out_valid  = out_valid_reg;
    assign image_col  = col_reg;
    assign image_row  = row_reg;
    assign zero_depth = zd_reg;

endmodule
